>>> hdl/mtbc_pkg.sv
// ============================================================================
// Markup tag balance checker package
// Shared item types, sizing constants and error codes for the tag checker.
// ============================================================================
package mtbc_pkg;

  // Sizing of the name stack.
  localparam int unsigned MAX_TAG_LEN = 32;
  localparam int unsigned STACK_DEPTH = 64;

  // Derived widths.
  localparam int unsigned CI_W   = $clog2(MAX_TAG_LEN + 1);   // name byte count
  localparam int unsigned OFS_W  = $clog2(MAX_TAG_LEN);       // byte offset in slot
  localparam int unsigned SP_W   = $clog2(STACK_DEPTH + 1);   // open name count
  localparam int unsigned IDX_W  = $clog2(STACK_DEPTH);       // slot index
  localparam int unsigned NADR_W = IDX_W + OFS_W;             // name store address
  localparam int unsigned NAME_DEPTH = STACK_DEPTH << OFS_W;

  // Character codes.
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'

  // First two name bytes of the void tags.
  localparam logic [15:0] VOID_BR = 16'h6272;  // "br"
  localparam logic [15:0] VOID_HR = 16'h6872;  // "hr"

  // Verdict codes.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_MISMATCH = 3'd1,
    ERR_EMPTY    = 3'd2,
    ERR_UNCLOSED = 3'd3,
    ERR_BOUND    = 3'd4
  } err_e;

  // One text byte.
  typedef struct packed {
    logic [7:0] char_in;
    logic       last;
  } in_item_t;

  // One verdict.
  typedef struct packed {
    logic       well_formed;
    logic [2:0] error_kind;
  } out_item_t;

endpackage

>>> hdl/markup_tag_balance_checker_unit.sv
// ============================================================================
// Markup tag balance checker
// Checks the nesting of markup tags in a byte stream using a name stack.
// ============================================================================
// Usage:
//   The input channel carries one text byte per item with a flag for the
//   final byte of the text. The output channel carries one verdict per text,
//   a well-formed flag and an error kind, issued for the byte marked last.
//   Both channels use valid/stall; an item moves on an edge with valid high
//   and stall low.
// Throughput: one byte per cycle while no verdict is blocked. Every byte does
//   one read of the name store and of the length store; the read is issued
//   while the byte is accepted and the registered data is consumed by the
//   evaluate stage. The last byte is registered in the evaluate stage, and
//   its verdict is registered in the output register.
// Stall: the verdict register holds while the receiver stalls. The block
//   keeps accepting bytes until a second last byte has to wait behind the
//   held verdict; only then is the input stalled.
// Reset: clears the stack pointer, tag state and latched error at once. The
//   name and length stores need no clearing. After each verdict the control
//   state returns to its reset values so the next text starts fresh.
// ============================================================================
module markup_tag_balance_checker_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mtbc_pkg::in_item_t in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mtbc_pkg::out_item_t out_item_o
);
  import mtbc_pkg::*;

  // Evaluate stage register.
  logic      s2_valid_q, s2_valid_d;
  in_item_t  s2_item_q;

  // Control state.
  logic [SP_W-1:0] sp_q, sp_d;
  logic            in_tag_q, in_tag_d;
  logic            closing_q, closing_d;
  logic [CI_W-1:0] ci_q, ci_d;
  logic            mism_q, mism_d;
  logic [15:0]     vprefix_q, vprefix_d;
  err_e            err_q, err_d;

  // Output register.
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q, out_item_d;

  // Stores.
  logic [7:0]      name_mem [NAME_DEPTH];
  logic [CI_W-1:0] len_mem  [STACK_DEPTH];
  logic [7:0]      name_rdata_q;
  logic [CI_W-1:0] len_rdata_q;
  logic            len_byp_q;
  logic [CI_W-1:0] len_byp_data_q;

  logic              name_we;
  logic [NADR_W-1:0] name_waddr;
  logic [NADR_W-1:0] name_raddr;
  logic              len_we;
  logic [IDX_W-1:0]  len_waddr;
  logic [IDX_W-1:0]  len_raddr;

  logic            s2_fire;
  logic            accept;
  logic [CI_W-1:0] top_len;
  logic [7:0]      ch;
  logic            is_void;
  err_e            verdict;

  // Handshake: the evaluate stage only waits when a verdict is blocked.
  assign s2_fire    = s2_valid_q && (!s2_item_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = s2_valid_q && !s2_fire;
  assign accept     = in_valid_i && !in_stall_o;

  // Length of the top name, with the same-cycle push forwarded.
  assign top_len = len_byp_q ? len_byp_data_q : len_rdata_q;
  assign ch      = s2_item_q.char_in;
  assign is_void = !closing_q && (ci_q == CI_W'(2)) &&
                   ((vprefix_q == VOID_BR) || (vprefix_q == VOID_HR));

  // Evaluate one byte against the stored stack.
  always_comb begin
    sp_d        = sp_q;
    in_tag_d    = in_tag_q;
    closing_d   = closing_q;
    ci_d        = ci_q;
    mism_d      = mism_q;
    vprefix_d   = vprefix_q;
    err_d       = err_q;
    name_we     = 1'b0;
    name_waddr  = {sp_q[IDX_W-1:0], ci_q[OFS_W-1:0]};
    len_we      = 1'b0;
    len_waddr   = sp_q[IDX_W-1:0];
    verdict     = ERR_NONE;
    out_valid_d = out_valid_q && out_stall_i;
    out_item_d  = out_item_q;

    if (s2_fire) begin
      if (err_q == ERR_NONE) begin
        if (!in_tag_q) begin
          if (ch == CH_LT) begin
            in_tag_d  = 1'b1;
            closing_d = 1'b0;
            ci_d      = '0;
            mism_d    = 1'b0;
            vprefix_d = '0;
          end
        end else if (ch == CH_GT) begin
          in_tag_d = 1'b0;
          if (!is_void) begin
            if (!closing_q) begin
              if (sp_q >= SP_W'(STACK_DEPTH)) begin
                err_d = ERR_BOUND;
              end else begin
                len_we = 1'b1;
                sp_d   = sp_q + SP_W'(1);
              end
            end else if (sp_q == '0) begin
              err_d = ERR_EMPTY;
            end else if (mism_q || (ci_q != top_len)) begin
              err_d = ERR_MISMATCH;
            end else begin
              sp_d = sp_q - SP_W'(1);
            end
          end
        end else if ((ch == CH_SLASH) && (ci_q == '0) && !closing_q) begin
          closing_d = 1'b1;
        end else if (ci_q >= CI_W'(MAX_TAG_LEN)) begin
          err_d = ERR_BOUND;
        end else begin
          if (ci_q < CI_W'(2)) begin
            vprefix_d = {vprefix_q[7:0], ch};
          end
          if (closing_q) begin
            if ((sp_q != '0) && ((ci_q >= top_len) || (name_rdata_q != ch))) begin
              mism_d = 1'b1;
            end
          end else if (sp_q < SP_W'(STACK_DEPTH)) begin
            name_we = 1'b1;
          end
          ci_d = ci_q + CI_W'(1);
        end
      end

      // Verdict on the last byte, then back to the reset state.
      if (s2_item_q.last) begin
        if (err_d != ERR_NONE) begin
          verdict = err_d;
        end else if (in_tag_d) begin
          verdict = ERR_BOUND;
        end else if (sp_d != '0) begin
          verdict = ERR_UNCLOSED;
        end
        out_valid_d            = 1'b1;
        out_item_d.well_formed = (verdict == ERR_NONE);
        out_item_d.error_kind  = verdict;
        sp_d      = '0;
        in_tag_d  = 1'b0;
        closing_d = 1'b0;
        ci_d      = '0;
        mism_d    = 1'b0;
        vprefix_d = '0;
        err_d     = ERR_NONE;
      end
    end
  end

  // Read addresses follow the next state, so a held byte re-reads its data.
  always_comb begin
    len_raddr  = IDX_W'(sp_d - SP_W'(1));
    name_raddr = {len_raddr, ci_d[OFS_W-1:0]};
  end

  // Stage valid bookkeeping.
  always_comb begin
    s2_valid_d = s2_valid_q;
    if (accept) begin
      s2_valid_d = 1'b1;
    end else if (s2_fire) begin
      s2_valid_d = 1'b0;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      sp_q        <= '0;
      in_tag_q    <= 1'b0;
      closing_q   <= 1'b0;
      ci_q        <= '0;
      mism_q      <= 1'b0;
      vprefix_q   <= '0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
      len_byp_q   <= 1'b0;
    end else begin
      s2_valid_q  <= s2_valid_d;
      sp_q        <= sp_d;
      in_tag_q    <= in_tag_d;
      closing_q   <= closing_d;
      ci_q        <= ci_d;
      mism_q      <= mism_d;
      vprefix_q   <= vprefix_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
      len_byp_q   <= len_we && (len_waddr == len_raddr);
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s2_item_q <= in_item_i;
    end
    out_item_q     <= out_item_d;
    len_byp_data_q <= ci_q;
  end

  // Name store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    name_rdata_q <= name_mem[name_raddr];
    if (name_we) begin
      name_mem[name_waddr] <= ch;
    end
  end

  // Length store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    len_rdata_q <= len_mem[len_raddr];
    if (len_we) begin
      len_mem[len_waddr] <= ci_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule

>>> hdl/mtbc_checker.sv
// ============================================================================
// Markup tag balance checker port checker
// Watches the top-level ports and flags inconsistent verdicts or stalls.
// ============================================================================
module mtbc_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input mtbc_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input mtbc_pkg::out_item_t out_item_o
);
  import mtbc_pkg::*;

  // A stalled verdict stays in place.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_item_o)))
    else $error("verdict item changed while stalled");

  // The well-formed flag agrees with the error kind.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.well_formed == (out_item_o.error_kind == ERR_NONE)))
    else $error("well_formed disagrees with error_kind");

  // Only defined error kinds are reported.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.error_kind <= ERR_BOUND))
    else $error("undefined error kind");

  // The input only waits behind a verdict that the receiver holds back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a blocked verdict");

endmodule

bind markup_tag_balance_checker_unit mtbc_checker u_mtbc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

>>> sim/markup_tag_balance_checker_unit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Markup tag balance checker testbench
// Streams texts into the checker one byte per item and compares each verdict
// with a cycle-free model of the tag name stack kept in a scoreboard. Short
// hand-made texts come first. Generated texts follow: mostly nested tag
// trees with random names, plus noise, broken texts and one deep stack.
// Both channels idle at random in several load phases.
// ============================================================================
module markup_tag_balance_checker_unit_tb;
  import mtbc_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 650;
  localparam int unsigned MIN_TEXTS    = 48;
  localparam int unsigned LIMIT_CYCLES = 200000;
  localparam int unsigned HOLD_CYCLES  = 80;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned GEN_DEPTH    = 8;
  localparam int unsigned GEN_NAME_MAX = 40;

  typedef enum {LOAD_STEADY, LOAD_SLOW_SEND, LOAD_SLOW_TAKE, LOAD_MIXED} load_e;

  // Expected verdicts from a model of the name stack, checked in order.
  class tag_nest_scoreboard;
    logic [7:0]  names [STACK_DEPTH][MAX_TAG_LEN];
    int unsigned name_len [STACK_DEPTH];
    int unsigned depth;
    bit          in_tag;
    bit          closing;
    bit          differs;
    int unsigned name_pos;
    logic [15:0] head;
    err_e        latched;
    out_item_t   verdicts_due[$];
    int unsigned errors;
    int unsigned n_bytes;
    int unsigned n_verdicts;
    int unsigned kind_seen [8];

    function new();
      clear();
    endfunction

    // Control state back to its reset values; the stores stay as they are.
    function void clear();
      depth    = 0;
      in_tag   = 1'b0;
      closing  = 1'b0;
      differs  = 1'b0;
      name_pos = 0;
      head     = '0;
      latched  = ERR_NONE;
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    // Advances the model by one accepted byte.
    function void note_byte(in_item_t it);
      logic [7:0] c;
      err_e       kind;
      out_item_t  exp;
      c = it.char_in;
      n_bytes++;
      if (latched == ERR_NONE) begin
        if (!in_tag) begin
          if (c == CH_LT) begin
            in_tag   = 1'b1;
            closing  = 1'b0;
            name_pos = 0;
            differs  = 1'b0;
            head     = '0;
          end
        end else if (c == CH_GT) begin
          // End of tag: void names are skipped, others push, pop or fail.
          in_tag = 1'b0;
          if (closing || name_pos != 2 || (head != VOID_BR && head != VOID_HR)) begin
            if (!closing) begin
              if (depth >= STACK_DEPTH) begin
                latched = ERR_BOUND;
              end else begin
                name_len[depth] = name_pos;
                depth++;
              end
            end else if (depth == 0) begin
              latched = ERR_EMPTY;
            end else if (differs || name_pos != name_len[depth - 1]) begin
              latched = ERR_MISMATCH;
            end else begin
              depth--;
            end
          end
        end else if (c == CH_SLASH && name_pos == 0 && !closing) begin
          closing = 1'b1;
        end else if (name_pos >= MAX_TAG_LEN) begin
          latched = ERR_BOUND;
        end else begin
          // Name byte: stored for an opening tag, compared for a closing one.
          if (name_pos < 2) head = {head[7:0], c};
          if (closing) begin
            if (depth > 0 &&
                (name_pos >= name_len[depth - 1] || names[depth - 1][name_pos] != c))
              differs = 1'b1;
          end else if (depth < STACK_DEPTH) begin
            names[depth][name_pos] = c;
          end
          name_pos++;
        end
      end
      if (it.last) begin
        kind = latched;
        if (kind == ERR_NONE && in_tag) kind = ERR_BOUND;
        if (kind == ERR_NONE && depth != 0) kind = ERR_UNCLOSED;
        exp.well_formed = (kind == ERR_NONE);
        exp.error_kind  = kind;
        verdicts_due.push_back(exp);
        clear();
      end
    endfunction

    // Compares one delivered verdict with the oldest expectation.
    function void check_verdict(out_item_t got);
      out_item_t exp;
      if (verdicts_due.size() == 0) begin
        errors++;
        $error("verdict with none due: well_formed=%0b error_kind=%0d",
               got.well_formed, got.error_kind);
        return;
      end
      exp = verdicts_due.pop_front();
      n_verdicts++;
      kind_seen[exp.error_kind]++;
      if (got.well_formed !== exp.well_formed) begin
        errors++;
        $error("well_formed: expected %0b, actual %0b", exp.well_formed, got.well_formed);
      end
      if (got.error_kind !== exp.error_kind) begin
        errors++;
        $error("error_kind: expected %0d, actual %0d", exp.error_kind, got.error_kind);
      end
    endfunction
  endclass

  logic      clk;
  logic      rst_n;
  logic      byte_valid;
  logic      byte_stall;
  in_item_t  byte_item;
  logic      verdict_valid;
  logic      verdict_stall;
  out_item_t verdict_item;

  tag_nest_scoreboard sb = new();

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  bit          hold_req;
  bit          hold_taken;
  int unsigned hold_left;
  int unsigned cycle_cnt;
  int unsigned held_off_cycles;
  int unsigned items_sent;
  int unsigned texts_sent;

  logic [7:0]  text_q[$];
  logic [7:0]  gen_name [GEN_DEPTH][GEN_NAME_MAX];
  int unsigned gen_len [GEN_DEPTH];

  markup_tag_balance_checker_unit dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (byte_valid),
    .in_stall_o  (byte_stall),
    .in_item_i   (byte_item),
    .out_valid_o (verdict_valid),
    .out_stall_i (verdict_stall),
    .out_item_o  (verdict_item)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, plus one long hold-off on request.
  always @(negedge clk) begin
    if (hold_req && !hold_taken) begin
      hold_taken = 1'b1;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      verdict_stall <= 1'b1;
    end else begin
      verdict_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Monitors on both channels feed the scoreboard.
  always @(posedge clk) begin
    cycle_cnt++;
    if (rst_n) begin
      if (byte_valid && byte_stall) held_off_cycles++;
      if (byte_valid && !byte_stall) sb.note_byte(byte_item);
      if (verdict_valid && !verdict_stall) sb.check_verdict(verdict_item);
    end
  end

  // Watchdog.
  initial begin
    while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
    $display("[markup_tag_balance_checker_unit] ERROR");
    $finish;
  end

  // Offers one item after a random gap and waits until it is taken.
  task automatic push_byte(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Sends the buffered text, marking its final byte.
  task automatic send_text();
    in_item_t it;
    for (int i = 0; i < text_q.size(); i++) begin
      it.char_in = text_q[i];
      it.last    = (i == text_q.size() - 1);
      push_byte(it);
    end
    items_sent += text_q.size();
    texts_sent++;
  endtask

  function automatic void append_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  function automatic logic [7:0] rand_name_byte(bit lead);
    logic [7:0] c;
    do begin
      c = ($urandom_range(0, 15) == 0) ? CH_LT : 8'($urandom_range(0, 255));
    end while (c == CH_GT || (lead && c == CH_SLASH));
    return c;
  endfunction

  function automatic logic [7:0] rand_filler();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == CH_LT);
    return c;
  endfunction

  // Bytes that matter to the tag parser, mixed with arbitrary ones.
  function automatic logic [7:0] rand_noise_byte();
    case ($urandom_range(0, 7))
      0:       return CH_LT;
      1:       return CH_GT;
      2:       return CH_SLASH;
      3:       return VOID_BR[15:8];
      4:       return VOID_HR[15:8];
      5:       return VOID_BR[7:0];
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Mostly short names, some at the length bound, some close to a void name.
  function automatic void make_name(int unsigned slot);
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 8) begin
      gen_len[slot]     = 2;
      gen_name[slot][0] = $urandom_range(0, 1) ? VOID_BR[15:8] : VOID_HR[15:8];
      gen_name[slot][1] = $urandom_range(0, 1) ? VOID_BR[7:0] : rand_name_byte(1'b0);
      return;
    end
    if (roll == 0)      gen_len[slot] = 0;
    else if (roll <= 6) gen_len[slot] = $urandom_range(1, 4);
    else if (roll == 7) gen_len[slot] = $urandom_range(MAX_TAG_LEN - 1, MAX_TAG_LEN + 1);
    else                gen_len[slot] = $urandom_range(5, 8);
    for (int i = 0; i < gen_len[slot]; i++) gen_name[slot][i] = rand_name_byte(i == 0);
  endfunction

  function automatic void add_tag(bit closing, int unsigned slot);
    text_q.push_back(CH_LT);
    if (closing) text_q.push_back(CH_SLASH);
    for (int i = 0; i < gen_len[slot]; i++) text_q.push_back(gen_name[slot][i]);
    text_q.push_back(CH_GT);
  endfunction

  // A nested tree of tags with voids and plain text, usually closed in full.
  function automatic void build_nested();
    int unsigned depth;
    int unsigned roll;
    depth = 0;
    repeat ($urandom_range(2, 12)) begin
      roll = $urandom_range(0, 99);
      if (roll < 35 && depth < GEN_DEPTH) begin
        make_name(depth);
        add_tag(1'b0, depth);
        depth++;
      end else if (roll < 65 && depth > 0) begin
        depth--;
        add_tag(1'b1, depth);
      end else if (roll < 75) begin
        text_q.push_back(CH_LT);
        text_q.push_back($urandom_range(0, 1) ? VOID_BR[15:8] : VOID_HR[15:8]);
        text_q.push_back(VOID_BR[7:0]);
        text_q.push_back(CH_GT);
      end else begin
        repeat ($urandom_range(1, 4)) text_q.push_back(rand_filler());
      end
    end
    if ($urandom_range(0, 99) < 85) begin
      while (depth > 0) begin
        depth--;
        add_tag(1'b1, depth);
      end
    end
  endfunction

  function automatic void build_random_text();
    int unsigned roll;
    int unsigned pos;
    text_q.delete();
    roll = $urandom_range(0, 99);
    if (roll < 65) begin
      build_nested();
      // Corrupt one byte or drop one.
      if (text_q.size() > 1 && $urandom_range(0, 3) == 0) begin
        pos = $urandom_range(0, text_q.size() - 1);
        if ($urandom_range(0, 1)) text_q[pos] = rand_noise_byte();
        else text_q.delete(pos);
      end
    end else if (roll < 80) begin
      repeat ($urandom_range(1, 24)) text_q.push_back(rand_noise_byte());
    end else begin
      build_nested();
      if ($urandom_range(0, 1)) begin
        // Text ends inside a tag.
        text_q.push_back(CH_LT);
        repeat ($urandom_range(0, 3)) text_q.push_back(rand_name_byte(1'b1));
      end else begin
        // A closing tag with nothing, or something else, left to match.
        text_q.push_back(CH_LT);
        text_q.push_back(CH_SLASH);
        text_q.push_back(rand_name_byte(1'b0));
        text_q.push_back(CH_GT);
      end
    end
    if (text_q.size() == 0) text_q.push_back(rand_filler());
  endfunction

  // Fills the stack to the top, pops and refills the last slot, then overflows.
  function automatic void build_deep_text();
    text_q.delete();
    repeat (STACK_DEPTH) begin
      text_q.push_back(CH_LT);
      text_q.push_back(CH_GT);
    end
    text_q.push_back(CH_LT);
    text_q.push_back(CH_SLASH);
    text_q.push_back(CH_GT);
    text_q.push_back(CH_LT);
    text_q.push_back(rand_name_byte(1'b1));
    text_q.push_back(CH_GT);
    text_q.push_back(CH_LT);
    text_q.push_back(CH_GT);
    text_q.push_back(rand_filler());
  endfunction

  // Stimulus and end of run.
  initial begin
    load_e load;
    bit    deep_done;
    byte_valid    = 1'b0;
    byte_item     = '0;
    verdict_stall = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    hold_taken    = 1'b0;
    hold_left     = 0;
    deep_done     = 1'b0;
    rst_n         = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Hand-made texts: zero byte outside tags and a void tag.
    text_q = {8'h00};
    append_str("<br>");
    send_text();
    // A '<' inside a name; the tag is never closed.
    text_q.delete();
    append_str("<a<>");
    send_text();
    // Closing void name on an empty stack.
    text_q.delete();
    append_str("</br>");
    send_text();
    // A '/' inside a name and the top byte value; the text ends in the tag.
    text_q.delete();
    append_str("<x/");
    text_q.push_back(8'hFF);
    send_text();
    // Mismatched close, then a byte ignored after the error.
    text_q.delete();
    append_str("<p></q>>");
    send_text();

    // Generated texts across load phases.
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS || texts_sent < MIN_TEXTS) begin
      load = load_e'((items_sent * 4 / RANDOM_ITEMS > 3) ? 3 : items_sent * 4 / RANDOM_ITEMS);
      case (load)
        LOAD_STEADY: begin
          send_idle_pct = 0;
          stall_pct     = 0;
          hold_req      = 1'b1;
        end
        LOAD_SLOW_SEND: begin
          send_idle_pct = 65;
          stall_pct     = 0;
        end
        LOAD_SLOW_TAKE: begin
          send_idle_pct = 0;
          stall_pct     = 65;
        end
        default: begin
          send_idle_pct = 25;
          stall_pct     = 25;
        end
      endcase
      if (load == LOAD_SLOW_TAKE && !deep_done) begin
        build_deep_text();
        deep_done = 1'b1;
      end else begin
        build_random_text();
      end
      send_text();
    end
    byte_valid <= 1'b0;
    stall_pct = 0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d texts: %0d bytes checked, %0d verdicts, %0d well formed,",
             texts_sent, sb.n_bytes, sb.n_verdicts, sb.kind_seen[ERR_NONE]);
    $display("errors seen: %0d mismatch, %0d empty, %0d unclosed, %0d bound; %0d held-off cycles.",
             sb.kind_seen[ERR_MISMATCH], sb.kind_seen[ERR_EMPTY],
             sb.kind_seen[ERR_UNCLOSED], sb.kind_seen[ERR_BOUND], held_off_cycles);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[markup_tag_balance_checker_unit] OK");
    end else begin
      $display("[markup_tag_balance_checker_unit] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/mtbc_pkg.sv
hdl/markup_tag_balance_checker_unit.sv
hdl/mtbc_checker.sv
sim/markup_tag_balance_checker_unit_tb.sv
